[sv/lfu_pkg.sv]
// package for the lfu replacement heap unit
// shared constants and types; no dependencies
package lfu_pkg;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgW   = 5;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EVICT,
    ST_DOWN,
    ST_APPEND,
    ST_UP,
    ST_DONE
  } lfu_state_e;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [KeyW-1:0]   evicted_key;
    logic [CountW-1:0] use_count;
  } lfu_result_t;
endpackage

[sv/lfu_front.sv]
// front part: accepts items and holds them in a two-entry queue
// depends on lfu_pkg
module lfu_front import lfu_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [KeyW-1:0] access_key_i,
  output logic                   q_valid_o,
  output logic [KeyW-1:0]        q_key_o,
  input  logic                   q_pop_i
);
  logic [KeyW-1:0] mem_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_key_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= access_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (q_pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !q_pop_i) |=> cnt_q == 2'd2) else $error("full queue lost item");
`endif
endmodule

[sv/lfu_back.sv]
// back part: key search and heap sift, one compare-and-swap step per cycle
// depends on lfu_pkg
module lfu_back import lfu_pkg::*; #(
  parameter int unsigned Capacity = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CfgW-1:0]   cap_i,
  input  logic              q_valid_i,
  input  logic [KeyW-1:0]   q_key_i,
  output logic              q_pop_o,
  output logic              res_valid_o,
  output lfu_result_t       res_o,
  input  logic              res_ready_i,
  output logic              idle_o
);
  localparam int unsigned PosW  = $clog2(Capacity);
  localparam int unsigned FillW = $clog2(Capacity + 1);

  logic [KeyW-1:0]   keys_q   [Capacity];
  logic [CountW-1:0] counts_q [Capacity];

  lfu_state_e      state_q, state_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] pos_q, pos_d;
  logic [FillW-1:0] cap_eff;
  logic [KeyW-1:0]  key_q;
  lfu_result_t      res_q, res_d;
  logic             rv_q, rv_d;

  logic              match;
  logic [PosW-1:0]   idx;
  logic [FillW:0]    lch, rch;
  logic [FillW-1:0]  best;
  logic [PosW-1:0]   par;
  logic              wr_a, wr_b;
  logic [PosW-1:0]   wa, wb;
  logic [KeyW-1:0]   wka, wkb;
  logic [CountW-1:0] wca, wcb;

  always_comb begin
    if (cap_i == '0) begin
      cap_eff = FillW'(1);
    end else if (32'(cap_i) > Capacity) begin
      cap_eff = FillW'(Capacity);
    end else begin
      cap_eff = FillW'(cap_i);
    end
  end

  assign idx   = pos_q[PosW-1:0];
  assign match = (keys_q[idx] == key_q);
  assign lch   = {pos_q, 1'b1};
  assign rch   = {pos_q, 1'b0} + (FillW+1)'(2);
  assign par   = PosW'((pos_q - FillW'(1)) >> 1);

  always_comb begin
    best = pos_q;
    if (lch < {1'b0, fill_q} &&
        counts_q[lch[PosW-1:0]] < counts_q[idx]) begin
      best = lch[FillW-1:0];
    end
    if (rch < {1'b0, fill_q} &&
        counts_q[rch[PosW-1:0]] < counts_q[best[PosW-1:0]]) begin
      best = rch[FillW-1:0];
    end
  end

  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i && !rv_q;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;
  assign idle_o      = (state_q == ST_IDLE) && !q_valid_i && !rv_q;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    pos_d   = pos_q;
    res_d   = res_q;
    rv_d    = rv_q;
    wr_a = 1'b0; wr_b = 1'b0;
    wa = idx; wb = idx;
    wka = keys_q[idx]; wkb = keys_q[idx];
    wca = counts_q[idx]; wcb = counts_q[idx];
    if (rv_q && res_ready_i) begin
      rv_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          pos_d   = '0;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (pos_q < fill_q && match) begin
          wr_a = 1'b1;
          wca  = (counts_q[idx] == CountMax) ? CountMax : counts_q[idx] + 16'd1;
          res_d.hit = 1'b1;
          res_d.evicted = 1'b0;
          res_d.evicted_key = '0;
          res_d.use_count = wca;
          state_d = ST_DOWN;
        end else if (pos_q + FillW'(1) < fill_q) begin
          pos_d = pos_q + FillW'(1);
        end else begin
          res_d.hit = 1'b0;
          res_d.evicted = 1'b0;
          res_d.evicted_key = '0;
          res_d.use_count = 16'd1;
          state_d = (fill_q >= cap_eff) ? ST_EVICT : ST_APPEND;
        end
      end
      ST_EVICT: begin
        res_d.evicted = 1'b1;
        res_d.evicted_key = keys_q[0];
        wr_a = 1'b1;
        wa   = '0;
        wka  = keys_q[PosW'(fill_q - FillW'(1))];
        wca  = counts_q[PosW'(fill_q - FillW'(1))];
        fill_d = fill_q - FillW'(1);
        pos_d  = '0;
        state_d = ST_DOWN;
      end
      ST_DOWN: begin
        if (best == pos_q) begin
          state_d = res_q.hit ? ST_DONE : ST_APPEND;
        end else begin
          wr_a = 1'b1; wa = idx;
          wka = keys_q[best[PosW-1:0]]; wca = counts_q[best[PosW-1:0]];
          wr_b = 1'b1; wb = best[PosW-1:0];
          wkb = keys_q[idx]; wcb = counts_q[idx];
          pos_d = best;
        end
      end
      ST_APPEND: begin
        wr_a = 1'b1;
        wa   = PosW'(fill_q);
        wka  = key_q;
        wca  = 16'd1;
        fill_d = fill_q + FillW'(1);
        pos_d  = fill_q;
        state_d = ST_UP;
      end
      ST_UP: begin
        if (pos_q != '0 && counts_q[par] > counts_q[idx]) begin
          wr_a = 1'b1; wa = idx;
          wka = keys_q[par]; wca = counts_q[par];
          wr_b = 1'b1; wb = par;
          wkb = keys_q[idx]; wcb = counts_q[idx];
          pos_d = FillW'(par);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rv_q) begin
          rv_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      keys_q[wa]   <= wka;
      counts_q[wa] <= wca;
    end
    if (wr_b) begin
      keys_q[wb]   <= wkb;
      counts_q[wb] <= wcb;
    end
    if (q_pop_o) begin
      key_q <= q_key_i;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      pos_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pos_q   <= pos_d;
      rv_q    <= rv_d;
    end
  end

`ifndef SYNTH
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= Capacity) else $error("fill above capacity");
  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_APPEND |=> fill_q == $past(fill_q) + FillW'(1))
    else $error("append did not grow fill");
  a_evict_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVICT |-> fill_q != '0) else $error("evict from empty heap");
  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> res_q.use_count != '0) else $error("zero use count");
`endif
endmodule

[sv/lfu_replacement_heap_unit.sv]
// top level of the lfu replacement heap unit
// depends on lfu_pkg, lfu_front, lfu_back
// An item is one key access, giving one result: hit flag, eviction flag and key, and the
// key's use count. A two-entry queue takes items while the heap engine works. The engine
// scans keys one slot per cycle, then sifts one level per cycle through a dual-write
// register file; the time an item takes is set by the linear key scan and the sift loop.
// The capacity on cfg_data_i is taken only while the unit is idle.
module lfu_replacement_heap_unit import lfu_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgW-1:0]          cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [KeyW-1:0]   access_key_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     hit_o,
  output logic                     evicted_o,
  output logic signed [KeyW-1:0]   evicted_key_o,
  output logic [CountW-1:0]        use_count_o
);
  logic [CfgW-1:0] cap_q;
  logic            qv, pop, idle;
  logic [KeyW-1:0] qk;
  lfu_result_t     res;

  assign cfg_ready_o = idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CfgW'(16);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  lfu_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .access_key_i,
    .q_valid_o(qv), .q_key_o(qk), .q_pop_i(pop)
  );

  lfu_back #(.Capacity(CAPACITY)) u_back (
    .clk_i, .rst_ni, .cap_i(cap_q), .q_valid_i(qv), .q_key_i(qk), .q_pop_o(pop),
    .res_valid_o(out_valid_o), .res_o(res), .res_ready_i(out_ready_i), .idle_o(idle)
  );

  assign hit_o         = res.hit;
  assign evicted_o     = res.evicted;
  assign evicted_key_o = res.evicted_key;
  assign use_count_o   = res.use_count;

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(use_count_o)) else $error("result changed");
  a_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle |-> !out_valid_o) else $error("idle with pending result");
`endif
endmodule

[sim/lfu_replacement_heap_unit_tb.sv]
// testbench for the lfu replacement heap unit: random and directed key accesses
// checked against an in-bench min-heap predictor; depends on lfu_pkg and the rtl
module lfu_replacement_heap_unit_tb;
  import lfu_pkg::*;

  localparam int unsigned Cap = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [KeyW-1:0] access_key_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic evicted_o;
  logic signed [KeyW-1:0] evicted_key_o;
  logic [CountW-1:0] use_count_o;

  always #1 clk_i = ~clk_i;

  lfu_replacement_heap_unit #(.CAPACITY(Cap)) u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .access_key_i,
    .out_valid_o, .out_ready_i, .hit_o, .evicted_o, .evicted_key_o, .use_count_o
  );

  // predictor state
  logic [KeyW-1:0] heap_keys [Cap];
  logic [CountW-1:0] heap_counts [Cap];
  int unsigned heap_fill;
  logic [CfgW-1:0] cap_reg;

  logic [KeyW-1:0] pending_keys [$];
  lfu_result_t expected_results [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned evictions_seen;
  int unsigned hold_cycles;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [KeyW-1:0] k;
    logic [CountW-1:0] c;
    k = heap_keys[a]; c = heap_counts[a];
    heap_keys[a] = heap_keys[b]; heap_counts[a] = heap_counts[b];
    heap_keys[b] = k; heap_counts[b] = c;
  endfunction

  function automatic void sift_down(int unsigned pos);
    int unsigned l, r, best;
    while (pos < heap_fill) begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      best = pos;
      if (l < heap_fill && heap_counts[l] < heap_counts[best]) best = l;
      if (r < heap_fill && heap_counts[r] < heap_counts[best]) best = r;
      if (best == pos) break;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  function automatic void sift_up(int unsigned pos);
    int unsigned parent;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (!(heap_counts[parent] > heap_counts[pos])) break;
      swap_slots(pos, parent);
      pos = parent;
    end
  endfunction

  function automatic lfu_result_t lfu_access(logic [KeyW-1:0] key);
    lfu_result_t res;
    int unsigned limit;
    limit = (cap_reg == 0) ? 1 : ((cap_reg > Cap) ? Cap : cap_reg);
    res = '0;
    for (int unsigned i = 0; i < heap_fill; i++) begin
      if (heap_keys[i] == key) begin
        if (heap_counts[i] != CountMax) heap_counts[i] = heap_counts[i] + 1'b1;
        res.hit = 1'b1;
        res.use_count = heap_counts[i];
        sift_down(i);
        return res;
      end
    end
    res.use_count = 16'd1;
    if (heap_fill >= limit) begin
      res.evicted = 1'b1;
      res.evicted_key = heap_keys[0];
      heap_fill--;
      heap_keys[0] = heap_keys[heap_fill];
      heap_counts[0] = heap_counts[heap_fill];
      sift_down(0);
    end
    heap_keys[heap_fill] = key;
    heap_counts[heap_fill] = 16'd1;
    heap_fill++;
    sift_up(heap_fill - 1);
    return res;
  endfunction

  // driver
  int unsigned send_gap;
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_results.push_back(lfu_access(access_key_i));
      in_valid_i <= 1'b0;
      send_gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) send_gap = 0;
    end else if (!in_valid_i && rst_ni) begin
      if (send_gap > 0) send_gap--;
      else if (pending_keys.size() > 0) begin
        access_key_i <= pending_keys.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  // monitor
  int unsigned recv_gap;
  always @(posedge clk_i) begin
    lfu_result_t want;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (hit_o) hits_seen++;
      if (evicted_o) evictions_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = expected_results.pop_front();
        if (hit_o !== want.hit || evicted_o !== want.evicted ||
            evicted_key_o !== want.evicted_key || use_count_o !== want.use_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0b ev=%0b key=%h cnt=%0d got hit=%0b ev=%0b key=%h cnt=%0d",
                     want.hit, want.evicted, want.evicted_key, want.use_count,
                     hit_o, evicted_o, evicted_key_o, use_count_o);
        end
      end
      out_ready_i <= 1'b0;
      recv_gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) recv_gap = 0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready_i <= 1'b0;
    end else if (rst_ni) begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_capacity(logic [CfgW-1:0] value);
    while (pending_keys.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_reg = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_random(int unsigned n, int unsigned pool);
    logic [KeyW-1:0] k;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) k = $urandom();
      else k = 32'h7000_0000 ^ $urandom_range(0, pool - 1) * 32'h0101_0013;
      pending_keys.push_back(k);
    end
  endtask

  initial begin
    heap_fill = 0;
    cap_reg = 5'd16;
    mismatches = 0;
    results_seen = 0;
    hits_seen = 0;
    evictions_seen = 0;
    hold_cycles = 0;
    send_gap = 0;
    recv_gap = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: key extremes, hits, fill and evict at reset capacity
    pending_keys.push_back(32'h8000_0000);
    pending_keys.push_back(32'h7FFF_FFFF);
    pending_keys.push_back(32'h0000_0000);
    pending_keys.push_back(32'hFFFF_FFFF);
    pending_keys.push_back(32'h7FFF_FFFF);
    pending_keys.push_back(32'h8000_0000);
    pending_keys.push_back(32'h7FFF_FFFF);
    for (int unsigned i = 0; i < 16; i++) pending_keys.push_back(32'h1000 + i);
    write_capacity(5'd0);
    pending_keys.push_back(32'hAAAA_5555);
    pending_keys.push_back(32'h5555_AAAA);
    pending_keys.push_back(32'h5555_AAAA);

    write_capacity(5'd31);
    // long receiver stall while the sender keeps offering
    queue_random(40, 24);
    hold_cycles = 300;
    queue_random(60, 24);
    write_capacity(5'd3);
    queue_random(80, 6);
    write_capacity(5'd16);
    queue_random(120, 22);
    write_capacity(5'd7);
    queue_random(80, 10);
    write_capacity(5'd1);
    queue_random(40, 3);
    write_capacity(5'd12);
    queue_random(80, 16);

    while (pending_keys.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d accesses: %0d hits, %0d evictions, capacities 0..31",
             results_seen, hits_seen, evictions_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
